>>> rtl/checked_memory_with_segment_guard_top_defines.svh
// assertion macros for the checked memory block
// used by the top level only; bodies are empty when SYNTHESIS is defined
`ifndef CHECKED_MEMORY_WITH_SEGMENT_GUARD_TOP_DEFINES_SVH
`define CHECKED_MEMORY_WITH_SEGMENT_GUARD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CMSG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CMSG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CMSG_ASSERT(name, clk, rst_n, prop, msg)
`define CMSG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/cmsg_pkg.sv
// shared types, sizes and codes for the checked memory with segment guard
// used by the controller, the datapath and the top level
package cmsg_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int SEGMENTS  = 8;
  localparam int OFF_W     = $clog2(MEM_BYTES);
  localparam int ROW_W     = OFF_W - 2;
  localparam int ROWS      = MEM_BYTES / 4;
  localparam int SEG_IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CFG_IDX_W = 1;

  // request function codes
  localparam logic [2:0] FN_LOAD    = 3'd0;
  localparam logic [2:0] FN_STORE   = 3'd1;
  localparam logic [2:0] FN_FETCH   = 3'd2;
  localparam logic [2:0] FN_SEG_SET = 3'd3;
  localparam logic [2:0] FN_PRELOAD = 3'd4;

  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_MISALIGNED = 2'd1;
  localparam logic [1:0] FAULT_ACCESS     = 2'd2;

  localparam logic [2:0] RIGHT_READ  = 3'b100;
  localparam logic [2:0] RIGHT_WRITE = 3'b010;
  localparam logic [2:0] RIGHT_EXEC  = 3'b001;

  localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [2:0]  width;
    logic [31:0] write_data;
    logic [2:0]  seg_slot;
    logic [31:0] seg_size;
    logic [2:0]  seg_perm;
  } in_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic load_item;
    logic exec;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

>>> rtl/cmsg_ctrl.sv
// controller: clearing pass after reset, request sequencing, output valid
// depends on cmsg_pkg
module cmsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_stall,
  input  cmsg_pkg::dp_status_t status,
  output cmsg_pkg::ctl_cmd_t   cmd,
  output logic                in_stall,
  output logic                out_valid
);
  import cmsg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   stall_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    stall_int = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        stall_int = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // result moves on once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          stall_int    = 1'b0;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            state_nxt     = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);
  end

  assign in_stall  = stall_int | ~rst_n;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/cmsg_dpath.sv
// datapath: config registers, segment table, range and segment checks,
// four byte-lane ram banks with clear port, output register; uses cmsg_pkg
module cmsg_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmsg_pkg::ctl_cmd_t            cmd,
  output cmsg_pkg::dp_status_t          status,
  input  cmsg_pkg::in_req_t             in_req,
  output cmsg_pkg::out_rsp_t            out_rsp,
  input  logic                          cfg_we,
  input  logic [cmsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import cmsg_pkg::*;

  logic [31:0]    ram_base_r;
  logic [16:0]    ram_size_r;
  in_req_t        item_r;
  logic [31:0]    seg_start_r  [SEGMENTS];
  logic [31:0]    seg_len_r    [SEGMENTS];
  logic [2:0]     seg_rights_r [SEGMENTS];
  logic [ROW_W-1:0] clr_row_r;

  logic [1:0]     fault_r;
  logic           rd_en_r;
  logic [1:0]     lo_r;
  logic [2:0]     w_r;
  logic [7:0]     rdata_r [4];
  out_rsp_t       out_rsp_r;

  // exec-cycle checks
  logic           w_ok, misaligned, in_ram, seg_ok, is_acc;
  logic [31:0]    diff;
  logic [32:0]    lim;
  logic [2:0]     need;
  logic [1:0]     fault;
  logic [OFF_W-1:0] off;
  logic           do_write, do_read, seg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r <= '0;
      ram_size_r <= 17'h10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAM_BASE: ram_base_r <= cfg_wdata;
        REG_RAM_SIZE: ram_size_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_req;
  end

  assign w_ok       = (item_r.width == 3'd1) || (item_r.width == 3'd2) ||
                      (item_r.width == 3'd4);
  assign misaligned = |(item_r.address[2:0] & (item_r.width - 3'd1));
  assign diff       = item_r.address - ram_base_r;
  assign lim        = ({16'b0, ram_size_r} > 33'(MEM_BYTES)) ? 33'(MEM_BYTES)
                                                           : {16'b0, ram_size_r};
  assign in_ram     = (item_r.address >= ram_base_r) &&
                      (({1'b0, diff} + {30'b0, item_r.width}) <= lim);
  assign off        = diff[OFF_W-1:0];
  assign is_acc     = (item_r.func == FN_LOAD) || (item_r.func == FN_STORE) ||
                      (item_r.func == FN_FETCH);

  always_comb begin
    case (item_r.func)
      FN_LOAD:  need = RIGHT_READ;
      FN_STORE: need = RIGHT_WRITE;
      default:  need = RIGHT_EXEC;
    endcase
  end

  // every live segment is compared in parallel
  always_comb begin
    logic [32:0] s_lo, s_hi, a_lo, a_hi;
    logic        ovl, bad, seen_exec;
    bad       = 1'b0;
    seen_exec = 1'b0;
    a_lo      = {1'b0, item_r.address};
    a_hi      = a_lo + {30'b0, item_r.width};
    for (int k = 0; k < SEGMENTS; k++) begin
      s_lo = {1'b0, seg_start_r[k]};
      s_hi = s_lo + {1'b0, seg_len_r[k]};
      ovl  = (seg_len_r[k] != '0) && (a_lo < s_hi) && (s_lo < a_hi);
      if (ovl && ((a_lo < s_lo) || (a_hi > s_hi) || ((seg_rights_r[k] & need) == '0)))
        bad = 1'b1;
      if (ovl && seg_rights_r[k][0]) seen_exec = 1'b1;
    end
    seg_ok = !bad && ((item_r.func != FN_FETCH) || seen_exec);
  end

  always_comb begin
    fault = FAULT_NONE;
    if (is_acc) begin
      if (!w_ok)            fault = FAULT_ACCESS;
      else if (misaligned)  fault = FAULT_MISALIGNED;
      else if (!in_ram)     fault = FAULT_ACCESS;
      else if (!seg_ok)     fault = FAULT_ACCESS;
    end else if (item_r.func == FN_PRELOAD) begin
      if (!w_ok || !in_ram) fault = FAULT_ACCESS;
    end else if (item_r.func != FN_SEG_SET) begin
      fault = FAULT_ACCESS;
    end
  end

  assign do_write = cmd.exec && (fault == FAULT_NONE) &&
                    ((item_r.func == FN_STORE) || (item_r.func == FN_PRELOAD));
  assign do_read  = (fault == FAULT_NONE) &&
                    ((item_r.func == FN_LOAD) || (item_r.func == FN_FETCH));
  assign seg_we   = cmd.exec && (item_r.func == FN_SEG_SET) &&
                    ({29'b0, item_r.seg_slot} < 32'(SEGMENTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SEGMENTS; k++) seg_len_r[k] <= '0;
    end else if (seg_we) begin
      seg_len_r[item_r.seg_slot[SEG_IDX_W-1:0]] <= item_r.seg_size;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_start_r[item_r.seg_slot[SEG_IDX_W-1:0]]  <= item_r.address;
      seg_rights_r[item_r.seg_slot[SEG_IDX_W-1:0]] <= item_r.seg_perm;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      fault_r <= fault;
      rd_en_r <= do_read;
      lo_r    <= off[1:0];
      w_r     <= item_r.width;
    end
  end

  // clearing pass row counter
  always_ff @(posedge clk) begin
    if (!rst_n)         clr_row_r <= '0;
    else if (cmd.clear) clr_row_r <= clr_row_r + ROW_W'(1);
  end

  assign status.clr_last = (clr_row_r == ROW_W'(ROWS - 1));

  // byte lanes: lane b holds bytes whose offset is b modulo four
  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [7:0]       mem [ROWS];
    logic [1:0]       n_b;
    logic [OFF_W-1:0] woff;
    logic             we_b;
    logic [31:0]      wshift;

    assign n_b    = 2'(b) - off[1:0];
    assign woff   = off + OFF_W'(n_b);
    assign we_b   = do_write && ({1'b0, n_b} < item_r.width);
    assign wshift = item_r.write_data >> {n_b, 3'b000};

    always_ff @(posedge clk) begin
      if (cmd.clear)  mem[clr_row_r] <= '0;
      else if (we_b)  mem[woff[OFF_W-1:2]] <= wshift[7:0];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) rdata_r[b] <= mem[off[OFF_W-1:2]];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] word;
    logic [1:0]  sel;
    word = '0;
    for (int n = 0; n < 4; n++) begin
      sel = lo_r + 2'(n);
      if (rd_en_r && (3'(n) < w_r)) word[8*n +: 8] = rdata_r[sel];
    end
    if (cmd.load_out) begin
      out_rsp_r.read_data <= word;
      out_rsp_r.fault     <= fault_r;
    end
  end

  assign out_rsp = out_rsp_r;

endmodule

>>> rtl/checked_memory_with_segment_guard_top.sv
// a request is captured when accepted; the exec state does the checks and the ram access,
// and the response state loads the result into the output register and may accept the next request
// the output register lets the next request be accepted while a result waits
// reset: synchronous active-low; afterwards a clearing pass zeroes all 16384 rows of the ram,
// one row of four bytes a cycle, with requests stalled; config writes are taken throughout
`include "checked_memory_with_segment_guard_top_defines.svh"
module checked_memory_with_segment_guard_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cmsg_pkg::in_req_t              in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cmsg_pkg::out_rsp_t             out_rsp,
  input  logic                           cfg_we,
  input  logic [cmsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import cmsg_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  cmsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  cmsg_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  `CMSG_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, cmd.exec, "accepted request not executed")
  `CMSG_ASSERT_NEXT(a_exec_spacing, clk, rst_n, cmd.exec, !cmd.exec, "exec in back-to-back cycles")
  `CMSG_ASSERT_NEXT(a_load_out_valid, clk, rst_n, cmd.load_out, out_valid, "loaded result not presented")
  `CMSG_ASSERT(a_clear_excl, clk, rst_n, !(cmd.clear && (cmd.exec || cmd.load_item)), "request taken during clear")

endmodule
